// ----- design/utf8sd_pkg.sv -----
// UTF-8 stream decoder: shared widths, codes, result types and queue sizing.
// No dependencies; imported by every module of the decoder.
package utf8sd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned TDATA_W = 24;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;

	localparam logic [BYTE_W-1:0] CONT_MASK = 8'b1100_0000;
	localparam logic [BYTE_W-1:0] CONT_PAT  = 8'b1000_0000;
	localparam logic [BYTE_W-1:0] MIN_LEAD2 = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD_E0   = 8'hE0;
	localparam logic [BYTE_W-1:0] LOW_E0    = 8'hA0;
	localparam logic [BYTE_W-1:0] LEAD_ED   = 8'hED;
	localparam logic [BYTE_W-1:0] HIGH_ED   = 8'h9F;
	localparam logic [BYTE_W-1:0] LEAD_F0   = 8'hF0;
	localparam logic [BYTE_W-1:0] LOW_F0    = 8'h90;
	localparam logic [BYTE_W-1:0] LEAD_F4   = 8'hF4;
	localparam logic [BYTE_W-1:0] HIGH_F4   = 8'h8F;

	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_TWO  = 3'd2;
	localparam logic [2:0] SEQ_THREE = 3'd3;
	localparam logic [2:0] SEQ_FOUR = 3'd4;

	// result queue; depth must be a power of two
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            endm;
		logic            last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} dec_t;

endpackage

// ----- design/utf8_stream_decoder_unit.sv -----
// UTF-8 stream decoder top level: input register, decoder and result queue.
// Depends on utf8sd_pkg, utf8sd_decode and utf8sd_outq.
//
// Usage: raw bytes enter on the s_ channel, one request per byte, with
// s_tlast high marking end of input (s_tdata is then ignored). Decoded code
// points leave on the m_ channel: m_tdata carries the code point, m_tuser
// flags the end-of-stream marker (code point 0) and m_tlast marks the final
// result caused by one input request.
// A result passes from the input register through the decoder into the result
// queue and is offered on m_ from there; while the queue lacks room the byte waits in the input register.
// Throughput: one byte per cycle while the queue has room; a byte or end
// request that yields two results (an interrupted sequence, or end with a
// sequence pending) writes both into the queue at once. Bytes that only start
// or extend a sequence yield no result.
// The four-entry result queue sets the stall behaviour: the input register
// is consumed only while two queue entries are free, so a stalled receiver
// back-pressures the sender after at most a few requests, and nothing is lost.
// Reset (arst_n low) empties the queue and the input register and returns
// the decoder to idle with no sequence pending.
module utf8_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [20:0] codepoint, [23:21] zero
	output logic        m_tuser,  // end_marker
	output logic        m_tlast   // last
);
	import utf8sd_pkg::*;

	logic              valid_s1, eoi_s1, fire, room;
	logic [BYTE_W-1:0] byte_s1;
	dec_t              dec;
	res_t              head;

	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	utf8sd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.eoi_s1  (eoi_s1),
		.dec     (dec)
	);

	utf8sd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (fire ? dec.cnt : 2'd0),
		.push_r0   (dec.r0),
		.push_r1   (dec.r1),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head)
	);

	assign m_tdata = TDATA_W'(head.cp);
	assign m_tuser = head.endm;
	assign m_tlast = head.last;

`ifndef SYNTHESIS
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
		else $error("end marker with code point or not last");
	a_cp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= TDATA_W'(MAX_CP))
		else $error("code point above U+10FFFF");
	a_eoi_yields: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi_s1 |-> dec.cnt != 2'd0)
		else $error("end of input produced no result");
`endif

endmodule

// ----- design/utf8sd_decode.sv -----
// UTF-8 stream decoder: sequence state and single-pass decode of one request.
// Depends on utf8sd_pkg.
module utf8sd_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [utf8sd_pkg::BYTE_W-1:0] byte_s1,
	input  logic                        eoi_s1,
	output utf8sd_pkg::dec_t            dec
);
	import utf8sd_pkg::*;

	logic [BYTE_W-1:0] lead_q, second_q;
	logic [CP_W-1:0]   partial_q;
	logic [1:0]        rem_q;
	logic [2:0]        len_q;

	logic [BYTE_W-1:0] lead_n, second_n;
	logic [CP_W-1:0]   partial_n;
	logic [1:0]        rem_n;
	logic [2:0]        len_n;

	// lead-byte decode, shared by the idle and interrupted paths
	logic              lp_emit;
	logic [CP_W-1:0]   lp_cp;
	logic [CP_W-1:0]   lp_partial;
	logic [1:0]        lp_rem;
	logic [2:0]        lp_len;

	logic              is_cont, bad;
	logic [BYTE_W-1:0] sec_c;
	logic [CP_W-1:0]   part_c;
	logic [1:0]        rem_c;
	logic [1:0]        n;
	res_t              r0, r1, end_res, repl_res;

	always_comb begin
		lp_emit    = 1'b0;
		lp_cp      = REPL_CP;
		lp_partial = '0;
		lp_rem     = 2'd0;
		lp_len     = SEQ_NONE;
		if (!byte_s1[7]) begin
			lp_emit = 1'b1;
			lp_cp   = CP_W'(byte_s1);
		end else if (byte_s1[7:5] == 3'b110) begin
			lp_len     = SEQ_TWO;
			lp_rem     = 2'd1;
			lp_partial = CP_W'(byte_s1[4:0]);
		end else if (byte_s1[7:4] == 4'b1110) begin
			lp_len     = SEQ_THREE;
			lp_rem     = 2'd2;
			lp_partial = CP_W'(byte_s1[3:0]);
		end else if (byte_s1[7:3] == 5'b11110) begin
			lp_len     = SEQ_FOUR;
			lp_rem     = 2'd3;
			lp_partial = CP_W'(byte_s1[2:0]);
		end else begin
			lp_emit = 1'b1;
		end
	end

	assign is_cont = (byte_s1 & CONT_MASK) == CONT_PAT;
	assign sec_c   = ((len_q - {1'b0, rem_q}) == 3'd1) ? byte_s1 : second_q;
	assign part_c  = {partial_q[CP_W-7:0], byte_s1[5:0]};
	assign rem_c   = rem_q - 2'd1;

	// validity checks on the completed sequence
	always_comb begin
		unique case (len_q)
			SEQ_TWO:   bad = lead_q < MIN_LEAD2;
			SEQ_THREE: bad = (lead_q == LEAD_E0 && sec_c < LOW_E0) ||
			                 (lead_q == LEAD_ED && sec_c > HIGH_ED);
			SEQ_FOUR:  bad = lead_q > LEAD_F4 ||
			                 (lead_q == LEAD_F0 && sec_c < LOW_F0) ||
			                 (lead_q == LEAD_F4 && sec_c > HIGH_F4);
			default:   bad = 1'b1;
		endcase
	end

	always_comb begin
		end_res  = '{cp: '0, endm: 1'b1, last: 1'b0};
		repl_res = '{cp: REPL_CP, endm: 1'b0, last: 1'b0};
		r0        = repl_res;
		r1        = end_res;
		n         = 2'd0;
		lead_n    = '0;
		second_n  = '0;
		partial_n = '0;
		rem_n     = 2'd0;
		len_n     = SEQ_NONE;
		if (eoi_s1) begin
			if (rem_q != 2'd0) begin
				n = 2'd2;
			end else begin
				r0 = end_res;
				n  = 2'd1;
			end
		end else if (rem_q == 2'd0) begin
			r0.cp = lp_cp;
			n     = {1'b0, lp_emit};
			if (!lp_emit) begin
				lead_n    = byte_s1;
				partial_n = lp_partial;
				rem_n     = lp_rem;
				len_n     = lp_len;
			end
		end else if (is_cont) begin
			if (rem_c == 2'd0) begin
				r0.cp = (bad || part_c > MAX_CP) ? REPL_CP : part_c;
				n     = 2'd1;
			end else begin
				lead_n    = lead_q;
				second_n  = sec_c;
				partial_n = part_c;
				rem_n     = rem_c;
				len_n     = len_q;
			end
		end else begin
			// interrupted sequence, byte retried as a lead
			r1 = '{cp: lp_cp, endm: 1'b0, last: 1'b0};
			n  = lp_emit ? 2'd2 : 2'd1;
			if (!lp_emit) begin
				lead_n    = byte_s1;
				partial_n = lp_partial;
				rem_n     = lp_rem;
				len_n     = lp_len;
			end
		end
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	assign dec = '{cnt: n, r0: r0, r1: r1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q    <= '0;
			second_q  <= '0;
			partial_q <= '0;
			rem_q     <= 2'd0;
			len_q     <= SEQ_NONE;
		end else if (fire) begin
			lead_q    <= lead_n;
			second_q  <= second_n;
			partial_q <= partial_n;
			rem_q     <= rem_n;
			len_q     <= len_n;
		end
	end

`ifndef SYNTHESIS
	a_len_tracks_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 2'd0 |-> len_q > {1'b0, rem_q})
		else $error("sequence length not above remaining count");
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q == 2'd0 |-> len_q == SEQ_NONE && partial_q == '0)
		else $error("idle decoder holds stale sequence state");
	a_eoi_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi_s1 |=> rem_q == 2'd0)
		else $error("end of input left a sequence pending");
`endif

endmodule

// ----- design/utf8sd_outq.sv -----
// UTF-8 stream decoder: small result queue taking up to two results per cycle.
// Depends on utf8sd_pkg.
module utf8sd_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_cnt,
	input  utf8sd_pkg::res_t push_r0,
	input  utf8sd_pkg::res_t push_r1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output utf8sd_pkg::res_t out_res
);
	import utf8sd_pkg::*;

	res_t             ent_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [OQ_CW-1:0] count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign out_res   = ent_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= OQ_CW'(OQ_DEPTH - 2);
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < OQ_DEPTH; i++) begin
			if (push_cnt != 2'd0 && wr_ptr_q == OQ_AW'(i))
				ent_q[i] <= push_r0;
			if (push_cnt == 2'd2 && wr_ptr_p1 == OQ_AW'(i))
				ent_q[i] <= push_r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + OQ_CW'(push_cnt) - OQ_CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd0 |-> count_q + OQ_CW'(push_cnt) <= OQ_CW'(OQ_DEPTH))
		else $error("result queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OQ_CW'(OQ_DEPTH))
		else $error("result queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != OQ_CW'(OQ_DEPTH) |-> (wr_ptr_q - rd_ptr_q) == count_q[OQ_AW-1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule

// ----- dv/utf8_stream_decoder_unit_tb.sv -----
// Self-checking testbench for utf8_stream_decoder_unit: a directed table, then random
// byte streams, checked against a code point predictor with its own decoder state.
// Depends on utf8sd_pkg and the decoder RTL.
module utf8_stream_decoder_unit_tb;
	import utf8sd_pkg::*;

	typedef struct packed {
		logic [7:0]      data_byte;
		logic            eoi;
		logic            typed;
		logic [CP_W-1:0] cp;
		logic            endm;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
	logic        s_tlast = 1'b0;    // end_of_input
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // [20:0] codepoint, [23:21] zero
	logic        m_tuser;           // end_marker
	logic        m_tlast;           // last

	// expected result typed into the table, travelling with the request
	logic            row_typed = 1'b0;
	logic [CP_W-1:0] row_cp = '0;
	logic            row_endm = 1'b0;

	// predictor state
	logic [7:0]      ld_byte = '0;
	logic [7:0]      sec_byte = '0;
	logic [CP_W-1:0] acc_val = '0;
	logic [1:0]      left_cnt = '0;
	logic [2:0]      seq_len = SEQ_NONE;

	res_t  cp_expect_q [$];
	stim_t stim_q [$];
	int    err_cnt = 0;
	logic [15:0] rx_cyc = '0;

	utf8_stream_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic res_t mk_res(input logic [CP_W-1:0] cp, input logic endm);
		res_t r;
		r.cp = cp;
		r.endm = endm;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic clear_seq();
		ld_byte = '0;
		sec_byte = '0;
		acc_val = '0;
		left_cnt = '0;
		seq_len = SEQ_NONE;
	endtask

	// byte seen while idle; returns 1 when it gives a result at once
	function automatic bit lead_decode(input logic [7:0] b, output logic [CP_W-1:0] cp);
		cp = REPL_CP;
		if (!b[7]) begin
			cp = {13'd0, b};
			return 1'b1;
		end
		if (b[7:5] == 3'b110) begin
			seq_len = SEQ_TWO;
			left_cnt = 2'd1;
			acc_val = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			seq_len = SEQ_THREE;
			left_cnt = 2'd2;
			acc_val = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			seq_len = SEQ_FOUR;
			left_cnt = 2'd3;
			acc_val = {18'd0, b[2:0]};
		end else begin
			return 1'b1;
		end
		ld_byte = b;
		sec_byte = '0;
		return 1'b0;
	endfunction

	task automatic decode_predict(input logic [7:0] b, input logic eoi, input bit keep);
		res_t r [2];
		int n;
		logic [CP_W-1:0] cp;
		logic bad;
		n = 0;
		if (eoi) begin
			if (left_cnt != 2'd0) begin
				r[n] = mk_res(REPL_CP, 1'b0);
				n++;
			end
			clear_seq();
			r[n] = mk_res('0, 1'b1);
			n++;
		end else if (left_cnt == 2'd0) begin
			if (lead_decode(b, cp)) begin
				r[n] = mk_res(cp, 1'b0);
				n++;
			end
		end else if ((b & CONT_MASK) == CONT_PAT) begin
			if (seq_len - {1'b0, left_cnt} == 3'd1)
				sec_byte = b;
			acc_val = {acc_val[14:0], b[5:0]};
			left_cnt = left_cnt - 2'd1;
			if (left_cnt == 2'd0) begin
				case (seq_len)
					SEQ_TWO: begin
						bad = ld_byte < MIN_LEAD2;
					end
					SEQ_THREE: begin
						bad = (ld_byte == LEAD_E0 && sec_byte < LOW_E0) ||
							(ld_byte == LEAD_ED && sec_byte > HIGH_ED);
					end
					SEQ_FOUR: begin
						bad = ld_byte > LEAD_F4 ||
							(ld_byte == LEAD_F0 && sec_byte < LOW_F0) ||
							(ld_byte == LEAD_F4 && sec_byte > HIGH_F4);
					end
					default: begin
						bad = 1'b1;
					end
				endcase
				r[n] = mk_res((bad || acc_val > MAX_CP) ? REPL_CP : acc_val, 1'b0);
				n++;
				clear_seq();
			end
		end else begin
			// interrupted sequence: replacement, then the byte starts afresh
			r[n] = mk_res(REPL_CP, 1'b0);
			n++;
			clear_seq();
			if (lead_decode(b, cp)) begin
				r[n] = mk_res(cp, 1'b0);
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			r[i].last = (i == n - 1);
			if (keep)
				cp_expect_q.push_back(r[i]);
		end
	endtask

	task automatic add_row(input logic [7:0] b, input logic eoi, input logic typed,
			input logic [CP_W-1:0] cp, input logic endm);
		stim_t s;
		s.data_byte = b;
		s.eoi = eoi;
		s.typed = typed;
		s.cp = cp;
		s.endm = endm;
		stim_q.push_back(s);
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_row(b, 1'b0, 1'b0, '0, 1'b0);
	endtask

	task automatic add_codepoint(input logic [CP_W-1:0] cp);
		if (cp < 21'h80) begin
			add_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end
	endtask

	task automatic add_random_seq();
		int sel;
		int len;
		int conts;
		logic [7:0] lead;
		sel = $urandom_range(0, 99);
		len = $urandom_range(2, 4);
		lead = 8'($urandom_range(0, 255));
		case (len)
			2: lead = {3'b110, lead[4:0]};
			3: lead = {4'b1110, lead[3:0]};
			default: lead = {5'b11110, lead[2:0]};
		endcase
		if (sel < 40) begin
			case ($urandom_range(0, 3))
				0: add_codepoint(21'($urandom_range(0, 'h7F)));
				1: add_codepoint(21'($urandom_range('h80, 'h7FF)));
				2: add_codepoint(21'($urandom_range('h800, 'hFFFF)));
				default: add_codepoint(21'($urandom_range('h10000, 'h10FFFF)));
			endcase
		end else if (sel < 80) begin
			// full length with random content, or cut short
			conts = (sel < 65) ? len - 1 : $urandom_range(0, len - 2);
			add_byte(lead);
			for (int i = 0; i < conts; i++)
				add_byte(8'h80 | 8'($urandom_range(0, 63)));
		end else if (sel < 93) begin
			add_byte(8'($urandom_range(0, 255)));
		end else begin
			add_row(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0, 1'b0);
		end
	endtask

	task automatic send(input stim_t s);
		s_tdata <= s.data_byte;
		s_tlast <= s.eoi;
		row_typed <= s.typed;
		row_cp <= s.cp;
		row_endm <= s.endm;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 16'd1;
		case (rx_cyc[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= $urandom_range(0, 3) != 0;
			2'd2: m_tready <= $urandom_range(0, 3) == 0;
			default: m_tready <= rx_cyc[3];
		endcase
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_predict(s_tdata, s_tlast, !row_typed);
				if (row_typed) begin
					e = mk_res(row_cp, row_endm);
					e.last = 1'b1;
					cp_expect_q.push_back(e);
				end
			end
			if (m_tvalid && m_tready) begin
				if (cp_expect_q.size() == 0) begin
					$display("%0t: result with none pending: cp %h end %b last %b",
						$time, m_tdata, m_tuser, m_tlast);
					err_cnt++;
				end else begin
					e = cp_expect_q.pop_front();
					if (m_tdata !== {3'b000, e.cp}) begin
						$display("%0t: codepoint exp %h act %h", $time, e.cp, m_tdata);
						err_cnt++;
					end
					if (m_tuser !== e.endm) begin
						$display("%0t: end marker exp %b act %b", $time, e.endm, m_tuser);
						err_cnt++;
					end
					if (m_tlast !== e.last) begin
						$display("%0t: last exp %b act %b", $time, e.last, m_tlast);
						err_cnt++;
					end
				end
			end
		end
	end

	initial begin
		int idx;
		int burst;
		int gap;
		int wait_cnt;
		add_row(8'h00, 1'b0, 1'b1, 21'h0, 1'b0);
		add_row(8'h7F, 1'b0, 1'b1, 21'h7F, 1'b0);
		add_row(8'h80, 1'b0, 1'b1, REPL_CP, 1'b0);  // stray continuation
		add_row(8'hFF, 1'b0, 1'b1, REPL_CP, 1'b0);  // invalid lead
		add_row(8'hA5, 1'b1, 1'b1, 21'h0, 1'b1);    // end while idle
		add_byte(8'hC1);                            // overlong two-byte
		add_byte(8'hBF);
		add_byte(8'hE0);                            // overlong three-byte
		add_byte(8'h9F);
		add_byte(8'hBF);
		add_byte(8'hED);                            // surrogate
		add_byte(8'hA0);
		add_byte(8'h80);
		add_byte(8'hF4);                            // above U+10FFFF
		add_byte(8'h90);
		add_byte(8'h80);
		add_byte(8'h80);
		add_byte(8'hF5);                            // lead F5 gathered in full
		add_byte(8'h80);
		add_byte(8'h80);
		add_byte(8'h80);
		add_byte(8'hE2);                            // interrupted, two results
		add_byte(8'h41);
		add_byte(8'hF0);                            // end while pending
		add_row(8'h5A, 1'b1, 1'b0, '0, 1'b0);
		while (stim_q.size() < 950)
			add_random_seq();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < stim_q.size()) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && idx < stim_q.size(); k++) begin
				send(stim_q[idx]);
				idx++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		wait_cnt = 0;
		while (cp_expect_q.size() != 0 && wait_cnt < 5000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (8) @(posedge clk);
		if (cp_expect_q.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, cp_expect_q.size());
		if (err_cnt == 0 && cp_expect_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#(12 * 300000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
design/utf8sd_pkg.sv
design/utf8sd_decode.sv
design/utf8sd_outq.sv
design/utf8_stream_decoder_unit.sv
dv/utf8_stream_decoder_unit_tb.sv
